### rtl/srlt_pkg.sv
// Package for the session reverse lookup table: field widths, tuple layout,
// operation codes and the command/status structs between controller and datapath.
// No dependencies.
package srlt_pkg;

	localparam int SESSIONS = 1024;
	localparam int SID_W    = 10;
	localparam int IP_W     = 32;
	localparam int PORT_W   = 16;
	localparam int KIND_W   = 2;

	// Index width of the stores, and a compare width that holds both the
	// session field and the depth itself.
	localparam int IDX_W = (SESSIONS > 1) ? $clog2(SESSIONS) : 1;
	localparam int CMP_W = ((SID_W > IDX_W) ? SID_W : IDX_W) + 1;

	typedef enum logic [KIND_W-1:0] {
		KIND_INSERT  = 2'd0,
		KIND_RELEASE = 2'd1,
		KIND_LOOKUP  = 2'd2
	} kind_t;

	typedef enum logic {
		RES_LOOKUP  = 1'b0,
		RES_RELEASE = 1'b1
	} res_kind_t;

	typedef struct packed {
		logic [IP_W-1:0]   my_ip;
		logic [IP_W-1:0]   their_ip;
		logic [PORT_W-1:0] my_port;
		logic [PORT_W-1:0] their_port;
	} tuple_t;

	typedef struct packed {
		logic      sweep;
		logic      wr_tuple;
		logic      rd;
		logic      clr_valid;
		logic      load_out;
		res_kind_t res_kind;
	} cmd_t;

	typedef struct packed {
		logic sweep_last;
		logic hit;
		logic out_free;
	} stat_t;

endpackage

### rtl/srlt_req_if.sv
// Request channel of the session reverse lookup table: valid/ready plus one item.
// Depends on srlt_pkg for the field widths.
interface srlt_req_if;
	logic                            valid;
	logic                            ready;
	logic [srlt_pkg::KIND_W-1:0]     kind;
	logic [srlt_pkg::SID_W-1:0]      session_id;
	logic [srlt_pkg::IP_W-1:0]       my_ip;
	logic [srlt_pkg::IP_W-1:0]       their_ip;
	logic [srlt_pkg::PORT_W-1:0]     my_port;
	logic [srlt_pkg::PORT_W-1:0]     their_port;

	modport source (
		output valid, kind, session_id, my_ip, their_ip, my_port, their_port,
		input  ready
	);
	modport sink (
		input  valid, kind, session_id, my_ip, their_ip, my_port, their_port,
		output ready
	);
endinterface

### rtl/srlt_rsp_if.sv
// Result channel of the session reverse lookup table: valid/ready plus one result.
// Depends on srlt_pkg for the field widths.
interface srlt_rsp_if;
	logic                            valid;
	logic                            ready;
	logic                            result_kind;
	logic [srlt_pkg::SID_W-1:0]      result_session;
	logic [srlt_pkg::IP_W-1:0]       out_my_ip;
	logic [srlt_pkg::IP_W-1:0]       out_their_ip;
	logic [srlt_pkg::PORT_W-1:0]     out_my_port;
	logic [srlt_pkg::PORT_W-1:0]     out_their_port;

	modport source (
		output valid, result_kind, result_session, out_my_ip, out_their_ip,
		       out_my_port, out_their_port,
		input  ready
	);
	modport sink (
		input  valid, result_kind, result_session, out_my_ip, out_their_ip,
		       out_my_port, out_their_port,
		output ready
	);
endinterface

### rtl/srlt_ctrl.sv
// Controller of the session reverse lookup table: clearing pass, request
// decode and result hand-off. Depends on srlt_pkg.
module srlt_ctrl (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        in_valid,
	input  logic [srlt_pkg::KIND_W-1:0] in_kind,
	output logic                        in_ready,
	input  srlt_pkg::stat_t             stat,
	output srlt_pkg::cmd_t              cmd
);
	import srlt_pkg::*;

	typedef enum logic [1:0] {
		ST_SWEEP,
		ST_IDLE,
		ST_RESP
	} state_t;

	state_t state_q, state_d;
	logic   rel_q, rel_d;
	logic   need_result;

	always_comb begin
		cmd         = '0;
		state_d     = state_q;
		rel_d       = rel_q;
		in_ready    = 1'b0;
		need_result = 1'b0;
		unique case (state_q)
			ST_SWEEP: begin
				cmd.sweep = 1'b1;
				if (stat.sweep_last) begin
					state_d = ST_IDLE;
				end
			end
			ST_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					case (in_kind) inside
						KIND_INSERT: begin
							cmd.wr_tuple = 1'b1;
						end
						KIND_RELEASE, KIND_LOOKUP: begin
							cmd.rd  = 1'b1;
							rel_d   = (in_kind == KIND_RELEASE);
							state_d = ST_RESP;
						end
						default: begin
							// The unused code is dropped without effect.
						end
					endcase
				end
			end
			ST_RESP: begin
				// A release of an entry that is not valid gives no notice.
				need_result = !rel_q || stat.hit;
				if (!need_result) begin
					cmd.clr_valid = rel_q;
					state_d       = ST_IDLE;
				end else if (stat.out_free) begin
					cmd.load_out  = 1'b1;
					cmd.res_kind  = rel_q ? RES_RELEASE : RES_LOOKUP;
					cmd.clr_valid = rel_q;
					state_d       = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_SWEEP;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_SWEEP;
			rel_q   <= 1'b0;
		end else begin
			state_q <= state_d;
			rel_q   <= rel_d;
		end
	end

endmodule

### rtl/srlt_dp.sv
// Datapath of the session reverse lookup table: tuple store, valid-bit store,
// clearing counter and result register. Depends on srlt_pkg.
module srlt_dp (
	input  logic                       clk,
	input  logic                       arst_n,
	input  srlt_pkg::cmd_t             cmd,
	output srlt_pkg::stat_t            stat,
	input  logic [srlt_pkg::SID_W-1:0] in_sid,
	input  srlt_pkg::tuple_t           in_tuple,
	input  logic                       out_ready,
	output logic                       out_valid,
	output logic                       out_kind,
	output logic [srlt_pkg::SID_W-1:0] out_sid,
	output srlt_pkg::tuple_t           out_tuple
);
	import srlt_pkg::*;

	tuple_t tuple_mem [SESSIONS];
	logic   valid_mem [SESSIONS];

	logic [CMP_W-1:0] sid_ext;
	logic             in_range;
	logic [IDX_W-1:0] addr;

	logic [IDX_W-1:0] sweep_q;
	tuple_t           tuple_rd_q;
	logic             valid_rd_q;
	logic             in_range_q;
	logic [IDX_W-1:0] addr_q;
	logic [SID_W-1:0] sid_q;

	logic             out_valid_q;
	logic             out_kind_q;
	logic [SID_W-1:0] out_sid_q;
	tuple_t           out_tuple_q;

	assign sid_ext  = CMP_W'(in_sid);
	assign in_range = (sid_ext < CMP_W'(SESSIONS));
	assign addr     = sid_ext[IDX_W-1:0];

	// Tuple store: written on insert, read on release and lookup.
	always_ff @(posedge clk) begin
		if (cmd.wr_tuple && in_range) begin
			tuple_mem[addr] <= in_tuple;
		end
		if (cmd.rd) begin
			tuple_rd_q <= tuple_mem[addr];
		end
	end

	// Valid-bit store: one write port shared by the clearing pass, inserts
	// and releases, which never coincide.
	always_ff @(posedge clk) begin
		if (cmd.sweep) begin
			valid_mem[sweep_q] <= 1'b0;
		end else if (cmd.wr_tuple && in_range) begin
			valid_mem[addr] <= 1'b1;
		end else if (cmd.clr_valid && in_range_q) begin
			valid_mem[addr_q] <= 1'b0;
		end
		if (cmd.rd) begin
			valid_rd_q <= in_range && valid_mem[addr];
			in_range_q <= in_range;
			addr_q     <= addr;
			sid_q      <= in_sid;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sweep_q <= '0;
		end else if (cmd.sweep) begin
			sweep_q <= sweep_q + 1'b1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.load_out) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load_out) begin
			out_kind_q  <= cmd.res_kind;
			out_sid_q   <= sid_q;
			out_tuple_q <= in_range_q ? tuple_rd_q : '0;
		end
	end

	assign stat.sweep_last = (sweep_q == IDX_W'(SESSIONS - 1));
	assign stat.hit        = valid_rd_q;
	assign stat.out_free   = !out_valid_q || out_ready;

	assign out_valid = out_valid_q;
	assign out_kind  = out_kind_q;
	assign out_sid   = out_sid_q;
	assign out_tuple = out_tuple_q;

endmodule

### rtl/session_reverse_lookup_table_core.sv
// Session reverse lookup table, top level: controller plus datapath (srlt_pkg, interfaces).
// An insert writes the store when it is accepted; a release or lookup does a registered store
// read, then loads its result, if it has one, into the output register, which shows it.
// Inserts go at one per cycle while the core is idle; a release or lookup holds ready low
// until its result, if any, is loaded, and waits while an untaken result holds the output register.
// After reset the valid bits are cleared one entry a cycle, all 1024 entries, with ready low.
module session_reverse_lookup_table_core (
	input  logic       clk,
	input  logic       arst_n,
	srlt_req_if.sink   req,
	srlt_rsp_if.source rsp
);
	import srlt_pkg::*;

	// Command and status between the controller and the datapath.
	cmd_t   cmd;
	stat_t  stat;
	tuple_t in_tuple;
	tuple_t out_tuple;

	// The request tuple is packed once here so the datapath sees one word.
	assign in_tuple.my_ip      = req.my_ip;
	assign in_tuple.their_ip   = req.their_ip;
	assign in_tuple.my_port    = req.my_port;
	assign in_tuple.their_port = req.their_port;

	// The controller owns the request ready: it is high only when no
	// release or lookup is in flight and the clearing pass is done. A
	// waiting result in the output register does not stop the next transfer
	// itself, but a lookup, or a release of a valid entry, then holds ready
	// low until that result has been taken and its own result is loaded.
	srlt_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (req.valid),
		.in_kind  (req.kind),
		.in_ready (req.ready),
		.stat     (stat),
		.cmd      (cmd)
	);

	// The datapath holds both stores and the result register that parts
	// the two channels.
	srlt_dp u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (cmd),
		.stat      (stat),
		.in_sid    (req.session_id),
		.in_tuple  (in_tuple),
		.out_ready (rsp.ready),
		.out_valid (rsp.valid),
		.out_kind  (rsp.result_kind),
		.out_sid   (rsp.result_session),
		.out_tuple (out_tuple)
	);

	assign rsp.out_my_ip      = out_tuple.my_ip;
	assign rsp.out_their_ip   = out_tuple.their_ip;
	assign rsp.out_my_port    = out_tuple.my_port;
	assign rsp.out_their_port = out_tuple.their_port;

endmodule

### rtl/srlt_checker.sv
// Port-level checks for the session reverse lookup table, bound to the top level.
// Depends on srlt_pkg and session_reverse_lookup_table_core.
module srlt_checker (
	input logic                        clk,
	input logic                        arst_n,
	input logic                        req_valid,
	input logic                        req_ready,
	input logic [srlt_pkg::KIND_W-1:0] req_kind,
	input logic                        rsp_valid,
	input logic                        rsp_ready,
	input logic                        rsp_kind,
	input logic [srlt_pkg::SID_W-1:0]  rsp_session
);
	import srlt_pkg::*;

	// After a release or lookup is accepted, ready is low in the next cycle.
	a_busy_after_read: assert property (@(posedge clk) disable iff (!arst_n)
		(req_valid && req_ready && (req_kind == KIND_RELEASE || req_kind == KIND_LOOKUP))
		|=> !req_ready)
		else $error("request accepted while a read was in flight");

	// A new result only appears just after requests were held off.
	a_result_source: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(rsp_valid) |-> !$past(req_ready))
		else $error("result appeared without a preceding read");

	a_rsp_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(rsp_valid && !rsp_ready) |=> rsp_valid)
		else $error("result withdrawn before transfer");

	a_rsp_stable: assert property (@(posedge clk) disable iff (!arst_n)
		(rsp_valid && !rsp_ready) |=> ($stable(rsp_kind) && $stable(rsp_session)))
		else $error("stalled result changed");

endmodule

bind session_reverse_lookup_table_core srlt_checker u_srlt_checker (
	.clk         (clk),
	.arst_n      (arst_n),
	.req_valid   (req.valid),
	.req_ready   (req.ready),
	.req_kind    (req.kind),
	.rsp_valid   (rsp.valid),
	.rsp_ready   (rsp.ready),
	.rsp_kind    (rsp.result_kind),
	.rsp_session (rsp.result_session)
);

### tb/testbench.sv
// Self-checking testbench for session_reverse_lookup_table_core: a shadow copy of the
// tuple store and valid bits predicts every lookup reply and release notice.
// Depends on srlt_pkg, srlt_req_if, srlt_rsp_if and the core itself.
module testbench;
	timeunit 1ns;
	timeprecision 1ps;

	import srlt_pkg::*;

	// Kind code 3 has no operation; the core must ignore it.
	localparam logic [KIND_W-1:0] KIND_UNUSED = 2'd3;
	localparam int MAX_WAIT = 7;
	localparam int SETTLE_CYCLES = 16;

	typedef struct packed {
		logic [KIND_W-1:0] kind;
		logic [SID_W-1:0]  sid;
		tuple_t            tup;
	} table_req_t;

	typedef struct packed {
		res_kind_t        kind;
		logic [SID_W-1:0] sid;
		tuple_t           tup;
	} table_rsp_t;

	logic clk;
	logic arst_n;

	srlt_req_if req_ch();
	srlt_rsp_if rsp_ch();

	session_reverse_lookup_table_core uut (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req_ch),
		.rsp    (rsp_ch)
	);

	// Shadow state. A session counts as written once any insert has reached it;
	// lookups are only ever aimed at written sessions, because the stored tuple
	// of an untouched entry is unspecified.
	tuple_t     shadow_tuple   [SESSIONS];
	bit         shadow_live    [SESSIONS];
	bit         shadow_written [SESSIONS];
	int         written_ids    [$];
	table_rsp_t pending_results[$];

	int error_count = 0;
	bit no_idle     = 1'b0;
	int ready_hold  = 0;

	always begin
		clk = 1'b0;
		#10;
		clk = 1'b1;
		#10;
	end

	// Updates the shadow table for one accepted request and queues the
	// result it must cause, if any.
	function automatic void predict_table_op(input table_req_t r);
		table_rsp_t res;
		bit in_range;
		in_range = (int'(r.sid) < SESSIONS);
		res.sid = r.sid;
		res.tup = '0;
		case (r.kind)
			KIND_INSERT: begin
				if (in_range) begin
					shadow_tuple[r.sid] = r.tup;
					shadow_live[r.sid] = 1'b1;
					if (!shadow_written[r.sid]) begin
						shadow_written[r.sid] = 1'b1;
						written_ids.push_back(int'(r.sid));
					end
				end
			end
			KIND_RELEASE: begin
				// A notice only goes out for a live entry; a second release
				// of the same session is silent.
				if (in_range) begin
					if (shadow_live[r.sid]) begin
						res.kind = RES_RELEASE;
						res.tup = shadow_tuple[r.sid];
						pending_results.push_back(res);
					end
					shadow_live[r.sid] = 1'b0;
				end
			end
			KIND_LOOKUP: begin
				// No validity check: a released entry still returns its
				// stale tuple.
				res.kind = RES_LOOKUP;
				if (in_range) begin
					res.tup = shadow_tuple[r.sid];
				end
				pending_results.push_back(res);
			end
			default: begin
			end
		endcase
	endfunction

	function automatic tuple_t random_tuple();
		return {$urandom, $urandom, 16'($urandom), 16'($urandom)};
	endfunction

	function automatic table_req_t make_req(input logic [KIND_W-1:0] kind,
			input int sid, input tuple_t tup);
		table_req_t r;
		r.kind = kind;
		r.sid = SID_W'(sid);
		r.tup = tup;
		return r;
	endfunction

	// Random request over sessions 0..sid_hi. A lookup that would hit an
	// untouched session is steered to a written one instead, or made an insert if none is written yet.
	function automatic table_req_t make_random_request(input int sid_hi);
		table_req_t r;
		int pick;
		pick = $urandom_range(0, 99);
		r.sid = SID_W'($urandom_range(0, sid_hi));
		r.tup = random_tuple();
		if (pick < 35) begin
			r.kind = KIND_INSERT;
		end else if (pick < 60) begin
			r.kind = KIND_RELEASE;
		end else if (pick < 95) begin
			r.kind = KIND_LOOKUP;
		end else begin
			r.kind = KIND_UNUSED;
		end
		if (r.kind == KIND_LOOKUP && !shadow_written[r.sid]) begin
			if (written_ids.size() > 0) begin
				r.sid = SID_W'(written_ids[$urandom_range(0, written_ids.size() - 1)]);
			end else begin
				r.kind = KIND_INSERT;
			end
		end
		return r;
	endfunction

	// Drives one request and returns at the edge where its transfer happens.
	// Valid stays high afterwards so that a zero gap gives back-to-back items.
	task automatic send_request(input table_req_t r);
		int gap;
		gap = no_idle ? 0 : $urandom_range(0, MAX_WAIT);
		if (gap > 0) begin
			req_ch.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		req_ch.valid      <= 1'b1;
		req_ch.kind       <= r.kind;
		req_ch.session_id <= r.sid;
		req_ch.my_ip      <= r.tup.my_ip;
		req_ch.their_ip   <= r.tup.their_ip;
		req_ch.my_port    <= r.tup.my_port;
		req_ch.their_port <= r.tup.their_port;
		@(posedge clk);
		while (req_ch.ready !== 1'b1) @(posedge clk);
		predict_table_op(r);
	endtask

	function automatic void compare_field(input string name, input logic [63:0] want,
			input logic [63:0] got);
		if (got !== want) begin
			$display("%0t: %s mismatch, expected %h, actual %h", $time, name, want, got);
			error_count++;
		end
	endfunction

	function automatic void check_result();
		table_rsp_t want;
		if (pending_results.size() == 0) begin
			$display("%0t: unexpected result, expected none, actual kind %b session %h",
				$time, rsp_ch.result_kind, rsp_ch.result_session);
			error_count++;
		end else begin
			want = pending_results.pop_front();
			compare_field("result_kind", 64'(want.kind), 64'(rsp_ch.result_kind));
			compare_field("result_session", 64'(want.sid), 64'(rsp_ch.result_session));
			compare_field("out_my_ip", 64'(want.tup.my_ip), 64'(rsp_ch.out_my_ip));
			compare_field("out_their_ip", 64'(want.tup.their_ip), 64'(rsp_ch.out_their_ip));
			compare_field("out_my_port", 64'(want.tup.my_port), 64'(rsp_ch.out_my_port));
			compare_field("out_their_port", 64'(want.tup.their_port),
				64'(rsp_ch.out_their_port));
		end
	endfunction

	// Result side: check every transfer, then hold ready low for a random
	// number of cycles before taking the next one.
	initial rsp_ch.ready = 1'b0;

	always @(posedge clk) begin
		if (arst_n === 1'b1 && rsp_ch.valid === 1'b1 && rsp_ch.ready === 1'b1) begin
			check_result();
			ready_hold = no_idle ? 0 : $urandom_range(0, MAX_WAIT);
		end else if (ready_hold > 0) begin
			ready_hold--;
		end
		rsp_ch.ready <= (arst_n === 1'b1) && (ready_hold == 0);
	end

	// Field extremes, alternating bit patterns, double release, release of an
	// untouched session, lookup of a stale entry and the unused kind code.
	task automatic test_directed_cases();
		tuple_t pat_a;
		pat_a = {32'hAAAA_AAAA, 32'h5555_5555, 16'hAAAA, 16'h5555};
		send_request(make_req(KIND_INSERT, 0, '0));
		send_request(make_req(KIND_INSERT, SESSIONS - 1, '1));
		send_request(make_req(KIND_LOOKUP, 0, random_tuple()));
		send_request(make_req(KIND_LOOKUP, SESSIONS - 1, '0));
		send_request(make_req(KIND_INSERT, 1, pat_a));
		send_request(make_req(KIND_LOOKUP, 1, '0));
		send_request(make_req(KIND_INSERT, 2, ~pat_a));
		send_request(make_req(KIND_LOOKUP, 2, '1));
		send_request(make_req(KIND_RELEASE, SESSIONS - 1, '0));
		send_request(make_req(KIND_RELEASE, SESSIONS - 1, '0));
		send_request(make_req(KIND_LOOKUP, SESSIONS - 1, '0));
		send_request(make_req(KIND_RELEASE, 700, random_tuple()));
		send_request(make_req(KIND_UNUSED, 0, '1));
		send_request(make_req(KIND_LOOKUP, 0, '0));
		send_request(make_req(KIND_UNUSED, 3, random_tuple()));
		send_request(make_req(KIND_INSERT, 0, random_tuple()));
		send_request(make_req(KIND_RELEASE, 0, '0));
		send_request(make_req(KIND_INSERT, 0, random_tuple()));
		send_request(make_req(KIND_LOOKUP, 0, '0));
		send_request(make_req(KIND_RELEASE, 1, '1));
		send_request(make_req(KIND_LOOKUP, 1, '0));
	endtask

	// Whole session lifetimes: insert, optional overwrite, lookups, release,
	// then optionally a stale lookup and a redundant release.
	task automatic test_session_lifecycles();
		int sid;
		int lookups;
		for (int n = 0; n < 70; n++) begin
			sid = $urandom_range(0, 1) ? $urandom_range(0, SESSIONS - 1) : $urandom_range(0, 15);
			send_request(make_req(KIND_INSERT, sid, random_tuple()));
			if ($urandom_range(0, 3) == 0) begin
				send_request(make_req(KIND_INSERT, sid, random_tuple()));
			end
			lookups = $urandom_range(0, 2);
			repeat (lookups) send_request(make_req(KIND_LOOKUP, sid, random_tuple()));
			send_request(make_req(KIND_RELEASE, sid, random_tuple()));
			if ($urandom_range(0, 1)) begin
				send_request(make_req(KIND_LOOKUP, sid, random_tuple()));
			end
			if ($urandom_range(0, 2) == 0) begin
				send_request(make_req(KIND_RELEASE, sid, random_tuple()));
			end
		end
	endtask

	// Mixed traffic, mostly on a small pool of sessions so that inserts,
	// releases and lookups collide often; now and then anywhere in the table.
	task automatic test_random_mix();
		for (int n = 0; n < 450; n++) begin
			send_request(make_random_request(($urandom_range(0, 4) == 0) ? SESSIONS - 1 : 63));
		end
	endtask

	// Neither side idles: requests are offered back to back and results are taken as soon as shown.
	task automatic test_back_to_back();
		no_idle = 1'b1;
		for (int n = 0; n < 220; n++) begin
			send_request(make_random_request(31));
		end
		no_idle = 1'b0;
	endtask

	initial begin
		arst_n = 1'b0;
		req_ch.valid = 1'b0;
		req_ch.kind = KIND_INSERT;
		req_ch.session_id = '0;
		req_ch.my_ip = '0;
		req_ch.their_ip = '0;
		req_ch.my_port = '0;
		req_ch.their_port = '0;
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;

		// The core clears its valid bits after reset with ready low; the
		// first transfer simply waits for that sweep to finish.
		test_directed_cases();
		test_session_lifecycles();
		test_random_mix();
		test_back_to_back();

		req_ch.valid <= 1'b0;
		while (pending_results.size() != 0) @(posedge clk);
		// Extra cycles catch any stray result after the last expected one.
		repeat (SETTLE_CYCLES) @(posedge clk);
		if (error_count == 0) begin
			$display("CHECK OK");
		end else begin
			$display("CHECK FAILED");
		end
		$finish;
	end

	initial begin
		#(4_000_000);
		$display("CHECK FAILED");
		$finish;
	end

endmodule
